### design/scci_pkg.sv
// Package for the coaxial sphere/cylinder intersection block.
// Pipe word type, stage numbering and the per-stage datapath function.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package scci_pkg;

  localparam int FRAC = 16;             // fraction bits of the fixed-point format
  localparam int NST  = 55;             // pipe stages, capture stage included

  // stage map
  localparam int K_SQ    = 1;           // squares of axis components
  localparam int K_SUM   = 2;           // squared length, invalid checks
  localparam int K_LEN0  = 3;           // axis length root, 16 stages
  localparam int K_DIVI  = 19;          // divider set-up
  localparam int K_DIV0  = 20;          // unit axis divide, 9 stages
  localparam int K_DOT   = 29;          // unit axis, dot products
  localparam int K_ALONG = 30;
  localparam int K_PROJ  = 31;
  localparam int K_RES   = 32;          // residual distance per component
  localparam int K_RSQ   = 33;
  localparam int K_DISC0 = 34;          // squared residual check, radius squares
  localparam int K_DISC1 = 35;          // emptiness, disc set-up
  localparam int K_H0    = 36;          // h root, 16 stages
  localparam int K_OFFS  = 52;
  localparam int K_CMUL  = 53;
  localparam int K_CTR   = 54;

  typedef enum logic [1:0] {
    ST_INVALID     = 2'd0,
    ST_UNSUPPORTED = 2'd1,
    ST_EMPTY       = 2'd2,
    ST_CIRCLE      = 2'd3
  } status_t;

  typedef struct packed {
    logic [2:0][32:0] d;      // sphere centre minus origin
    logic [2:0][31:0] o;
    logic [2:0][31:0] axm;    // axis magnitudes
    logic [2:0]       axn;    // axis signs
    logic [31:0]      rs;
    logic [31:0]      rc;
    logic             bad;
    logic             unsup;
    logic             empty;
    logic             two;
    logic [2:0][63:0] t;      // scratch products
    logic [2:0][63:0] u;
    logic [65:0]      rem;    // root remainder
    logic [31:0]      root;
    logic [2:0][47:0] dr;     // divide remainders
    logic [2:0][16:0] q;
    logic [2:0][17:0] a;      // unit axis
    logic [63:0]      along;
    logic [39:0]      xm;
    logic [39:0]      xp;
    logic [2:0][31:0] c0;
    logic [2:0][31:0] c1;
    status_t          st;
  } pipe_t;

  // divide by 2^FRAC, round half away from zero
  function automatic logic [63:0] rnd(input logic [63:0] v);
    logic [63:0] m;
    m = v[63] ? (64'd0 - v) : v;
    m = (m + (64'd1 << (FRAC - 1))) >> FRAC;
    return v[63] ? (64'd0 - m) : m;
  endfunction

  function automatic logic [31:0] sat32(input logic [63:0] v);
    if ($signed(v) > 64'sd2147483647) return 32'h7fff_ffff;
    if ($signed(v) < -64'sd2147483648) return 32'h8000_0000;
    return v[31:0];
  endfunction

  function automatic logic [63:0] sx33(input logic [32:0] v);
    return {{31{v[32]}}, v};
  endfunction

  function automatic pipe_t stage_fn(input int k, input pipe_t p, input logic [30:0] tol,
                                     input logic [61:0] tolsq);
    pipe_t              q;
    logic [65:0]        trial;
    logic [47:0]        dv;
    logic [63:0]        s64;
    logic [63:0]        rv;
    logic [63:0]        disc;
    logic [33:0]        rst;
    logic signed [50:0] p51;
    logic signed [57:0] p58;
    logic signed [57:0] p58b;
    logic [39:0]        al40;
    int                 bi;
    q = p;
    if (k == K_SQ) begin
      q.bad = ($signed(p.rs) <= 0) || ($signed(p.rc) <= 0);
      for (int i = 0; i < 3; i++) q.t[i] = {32'd0, p.axm[i]} * {32'd0, p.axm[i]};
    end else if (k == K_SUM) begin
      s64 = p.t[0] + p.t[1] + p.t[2];
      q.bad = p.bad || (s64 == 64'd0);
      q.rem = {2'b00, s64};
      q.root = '0;
    end else if ((k >= K_LEN0 && k < K_LEN0 + 16) || (k >= K_H0 && k < K_H0 + 16)) begin
      for (int j = 0; j < 2; j++) begin
        bi = 31 - 2 * (k - ((k >= K_H0) ? K_H0 : K_LEN0)) - j;
        trial = ({34'd0, q.root} << (bi + 1)) | (66'd1 << (2 * bi));
        if (q.rem >= trial) begin
          q.rem = q.rem - trial;
          q.root = q.root | (32'd1 << bi);
        end
      end
    end else if (k == K_DIVI) begin
      for (int i = 0; i < 3; i++) begin
        q.dr[i] = {p.axm[i], 16'd0} + {17'd0, p.root[31:1]};
        q.q[i] = '0;
      end
    end else if (k >= K_DIV0 && k < K_DIV0 + 9) begin
      for (int j = 0; j < 2; j++) begin
        bi = 16 - 2 * (k - K_DIV0) - j;
        if (bi >= 0) begin
          dv = {16'd0, p.root} << bi;
          for (int i = 0; i < 3; i++) begin
            if (q.dr[i] >= dv) begin
              q.dr[i] = q.dr[i] - dv;
              q.q[i] = q.q[i] | (17'd1 << bi);
            end
          end
        end
      end
    end else if (k == K_DOT) begin
      for (int i = 0; i < 3; i++) begin
        q.a[i] = p.axn[i] ? (18'd0 - {1'b0, p.q[i]}) : {1'b0, p.q[i]};
        p51 = $signed(p.d[i]) * $signed(q.a[i]);
        q.t[i] = {{13{p51[50]}}, p51};
      end
    end else if (k == K_ALONG) begin
      q.along = rnd(p.t[0] + p.t[1] + p.t[2]);
    end else if (k == K_PROJ) begin
      for (int i = 0; i < 3; i++) begin
        p58 = $signed(p.a[i]) * $signed(p.along[39:0]);
        q.t[i] = {{6{p58[57]}}, p58};
      end
    end else if (k == K_RES) begin
      for (int i = 0; i < 3; i++) begin
        rv = sx33(p.d[i]) - rnd(p.t[i]);
        rv = rv[63] ? (64'd0 - rv) : rv;
        if (rv > {33'd0, tol}) q.unsup = 1'b1;
        q.t[i] = rv;
      end
    end else if (k == K_RSQ) begin
      for (int i = 0; i < 3; i++) q.t[i] = {33'd0, p.t[i][30:0]} * {33'd0, p.t[i][30:0]};
    end else if (k == K_DISC0) begin
      s64 = p.t[0] + p.t[1] + p.t[2];
      if (s64 > {2'b00, tolsq}) q.unsup = 1'b1;
      q.t[0] = {32'd0, p.rs} * {32'd0, p.rs};
      q.t[1] = {32'd0, p.rc} * {32'd0, p.rc};
      q.t[2] = {33'd0, tol} * ({32'd0, p.rs} + (64'd1 << FRAC));
    end else if (k == K_DISC1) begin
      disc = p.t[0] - p.t[1];
      rst = {2'b00, p.rs} + {3'b000, tol};
      q.empty = (rst < {2'b00, p.rc}) || ($signed(disc) < $signed(64'd0 - p.t[2]));
      q.rem = ($signed(disc) <= $signed({33'd0, tol} << FRAC)) ? 66'd0 : {2'b00, disc};
      q.root = '0;
    end else if (k == K_OFFS) begin
      al40 = p.along[39:0];
      q.two = p.root > {1'b0, tol};
      q.xm = q.two ? (al40 - {8'd0, p.root}) : al40;
      q.xp = al40 + {8'd0, p.root};
    end else if (k == K_CMUL) begin
      for (int i = 0; i < 3; i++) begin
        p58 = $signed(p.a[i]) * $signed(p.xm);
        p58b = $signed(p.a[i]) * $signed(p.xp);
        q.t[i] = {{6{p58[57]}}, p58};
        q.u[i] = {{6{p58b[57]}}, p58b};
      end
    end else if (k == K_CTR) begin
      for (int i = 0; i < 3; i++) begin
        q.c0[i] = sat32({{32{p.o[i][31]}}, p.o[i]} + rnd(p.t[i]));
        q.c1[i] = sat32({{32{p.o[i][31]}}, p.o[i]} + rnd(p.u[i]));
      end
      if (p.bad) q.st = ST_INVALID;
      else if (p.unsup) q.st = ST_UNSUPPORTED;
      else if (p.empty) q.st = ST_EMPTY;
      else q.st = ST_CIRCLE;
    end
    return q;
  endfunction

endpackage
`default_nettype wire

### design/scci_if.sv
// Channel interfaces of the intersection block: input word and result word.
// Valid/ready handshake; no dependencies.
`timescale 1ns / 1ps
`default_nettype none
interface scci_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] sphere_x;
  logic [31:0] sphere_y;
  logic [31:0] sphere_z;
  logic [31:0] sphere_rad;
  logic [31:0] origin_x;
  logic [31:0] origin_y;
  logic [31:0] origin_z;
  logic [31:0] axis_x;
  logic [31:0] axis_y;
  logic [31:0] axis_z;
  logic [31:0] cyl_rad;
  modport source (output valid, sphere_x, sphere_y, sphere_z, sphere_rad, origin_x, origin_y,
                  origin_z, axis_x, axis_y, axis_z, cyl_rad, input ready);
  modport sink (input valid, sphere_x, sphere_y, sphere_z, sphere_rad, origin_x, origin_y,
                origin_z, axis_x, axis_y, axis_z, cyl_rad, output ready);
endinterface

interface scci_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [31:0] center_x;
  logic [31:0] center_y;
  logic [31:0] center_z;
  logic [17:0] normal_x;
  logic [17:0] normal_y;
  logic [17:0] normal_z;
  logic [30:0] circle_rad;
  logic        last;
  modport source (output valid, status, center_x, center_y, center_z, normal_x, normal_y,
                  normal_z, circle_rad, last, input ready);
  modport sink (input valid, status, center_x, center_y, center_z, normal_x, normal_y,
                normal_z, circle_rad, last, output ready);
endinterface
`default_nettype wire

### design/sphere_cylinder_coaxial_intersect.sv
// Top level: coaxial sphere / infinite cylinder intersection pipeline.
// Uses scci_pkg (pipe word, stage function) and scci_if (channel interfaces).
`timescale 1ns / 1ps
`default_nettype none
// Each input word (sphere, cylinder origin/axis/radius, signed Q16.16) runs through a
// 55-stage pipeline and leaves one result word (invalid, unsupported, empty or a single
// tangent circle) or two circle words, the second flagged last. A new word is taken every
// cycle while the pipe advances; an item with two circles holds the output stage until
// both its words are handed over. The long parts are the two 32-bit square roots (two
// result bits per stage) and the unit-axis divide (two quotient bits per stage). The whole
// pipe advances together when the output stage is empty or hands over its last word, so a
// stall holds everything. The user must write tolerance through cfg_we/cfg_data only
// while the block is idle; the block itself does not enforce this.
module sphere_cylinder_coaxial_intersect
  import scci_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic [30:0] cfg_data,
  scci_in_if.sink          in_ch,
  scci_out_if.source       out_ch
);

  logic [30:0]    tol_r;
  logic [61:0]    tolsq_r;      // tolerance squared, follows the register
  pipe_t          pipe_r [NST];
  logic [NST-1:0] vld_r;
  logic           idx_r;        // 0: first word of item, 1: second
  logic           adv;
  logic           last_w;
  logic           circ;
  pipe_t          cap;
  pipe_t          tl;

  assign tl     = pipe_r[NST-1];
  assign circ   = (tl.st == ST_CIRCLE);
  assign last_w = !circ || !tl.two || idx_r;
  assign adv    = !vld_r[NST-1] || (out_ch.ready && last_w);
  assign in_ch.ready = adv;

  // capture: centre offset and axis sign/magnitude
  always_comb begin
    cap = '0;
    cap.d[0] = {in_ch.sphere_x[31], in_ch.sphere_x} - {in_ch.origin_x[31], in_ch.origin_x};
    cap.d[1] = {in_ch.sphere_y[31], in_ch.sphere_y} - {in_ch.origin_y[31], in_ch.origin_y};
    cap.d[2] = {in_ch.sphere_z[31], in_ch.sphere_z} - {in_ch.origin_z[31], in_ch.origin_z};
    cap.o[0] = in_ch.origin_x;
    cap.o[1] = in_ch.origin_y;
    cap.o[2] = in_ch.origin_z;
    cap.axn = {in_ch.axis_z[31], in_ch.axis_y[31], in_ch.axis_x[31]};
    cap.axm[0] = in_ch.axis_x[31] ? (32'd0 - in_ch.axis_x) : in_ch.axis_x;
    cap.axm[1] = in_ch.axis_y[31] ? (32'd0 - in_ch.axis_y) : in_ch.axis_y;
    cap.axm[2] = in_ch.axis_z[31] ? (32'd0 - in_ch.axis_z) : in_ch.axis_z;
    cap.rs = in_ch.sphere_rad;
    cap.rc = in_ch.cyl_rad;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tol_r <= '0;
      vld_r <= '0;
      idx_r <= 1'b0;
    end else begin
      if (cfg_we) tol_r <= cfg_data;
      if (adv) begin
        vld_r <= {vld_r[NST-2:0], in_ch.valid};
        idx_r <= 1'b0;
      end else if (out_ch.ready) begin
        idx_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    tolsq_r <= {31'd0, tol_r} * {31'd0, tol_r};
    if (adv) begin
      pipe_r[0] <= cap;
      for (int k = 1; k < NST; k++) pipe_r[k] <= stage_fn(k, pipe_r[k-1], tol_r, tolsq_r);
    end
  end

  // result word: fields other than status and last are zero unless a circle
  assign out_ch.valid      = vld_r[NST-1];
  assign out_ch.status     = tl.st;
  assign out_ch.last       = last_w;
  assign out_ch.center_x   = circ ? (idx_r ? tl.c1[0] : tl.c0[0]) : 32'd0;
  assign out_ch.center_y   = circ ? (idx_r ? tl.c1[1] : tl.c0[1]) : 32'd0;
  assign out_ch.center_z   = circ ? (idx_r ? tl.c1[2] : tl.c0[2]) : 32'd0;
  assign out_ch.normal_x   = circ ? tl.a[0] : 18'd0;
  assign out_ch.normal_y   = circ ? tl.a[1] : 18'd0;
  assign out_ch.normal_z   = circ ? tl.a[2] : 18'd0;
  assign out_ch.circle_rad = circ ? tl.rc[30:0] : 31'd0;

endmodule
`default_nettype wire
